### sv/acfs_pkg.sv
// Shared types, constants and codes for the ambient color fade setup block.
package acfs_pkg;

	// Field widths
	localparam int CH_W    = 8;
	localparam int OFF_W   = 9;
	localparam int FRM_W   = 16;
	localparam int STEP_W  = 22;
	localparam int MODE_W  = 4;
	localparam int CFG_IDX_W = 2;

	// Fixed point: 16 fraction bits, step spread over 8 sub-frames per frame
	localparam int FRAC_BITS     = 16;
	localparam int STEP_DIV_LOG2 = 3;
	localparam int QSHIFT        = FRAC_BITS - STEP_DIV_LOG2;

	// Serial divider: two quotient bits per cycle
	localparam int DIVD_W  = STEP_W;
	localparam int DIV_CYC = DIVD_W / 2;
	localparam int ITER_W  = $clog2(DIV_CYC);
	localparam int REM_W   = FRM_W;

	// Grey level: (2R + 3G + B) / 6 by reciprocal multiply
	localparam int GREY_SUM_W   = 11;
	localparam int GREY_MUL_W   = 14;
	localparam int GREY_PROD_W  = GREY_SUM_W + GREY_MUL_W;
	localparam int GREY_SHIFT   = 16;
	localparam logic [GREY_MUL_W-1:0] GREY6_MUL = 14'd10923;

	// Target sum before clamping, signed
	localparam int TSUM_W = 11;

	localparam logic [CH_W-1:0] CH_MAX = 8'hFF;

	// Command modes
	localparam logic [MODE_W-1:0] MODE_LIVE         = 4'd0;
	localparam logic [MODE_W-1:0] MODE_LIVE_HALF    = 4'd1;
	localparam logic [MODE_W-1:0] MODE_LIVE_GREY6   = 4'd2;
	localparam logic [MODE_W-1:0] MODE_LIVE_GREY12  = 4'd3;
	localparam logic [MODE_W-1:0] MODE_BASE_ADD     = 4'd4;
	localparam logic [MODE_W-1:0] MODE_BASE_HALF    = 4'd5;
	localparam logic [MODE_W-1:0] MODE_BASE_GREY6   = 4'd6;
	localparam logic [MODE_W-1:0] MODE_BASE_GREY12  = 4'd7;
	localparam logic [MODE_W-1:0] MODE_BASE_ONLY    = 4'd8;
	localparam logic [MODE_W-1:0] MODE_BASE_REPEAT  = 4'd9;
	localparam logic [MODE_W-1:0] MODE_CLEAR        = 4'd10;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_RED   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_GREEN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_BLUE  = 2'd2;

	// Channel indexes
	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GREY,
		ST_TGT,
		ST_LOAD,
		ST_DIV,
		ST_STORE,
		ST_DONE
	} acfs_state_t;

	// Controller to datapath
	typedef struct packed {
		logic       capture;
		logic       grey_en;
		logic       tgt_en;
		logic       div_load;
		logic       div_step;
		logic       step_store;
		logic       finish;
		logic [1:0] chan;
	} acfs_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic no_work;
		logic frames_zero;
		logic out_busy;
	} acfs_stat_t;

endpackage

### sv/acfs_ctrl.sv
// Sequencer for one fade command: grey, target, three divisions for a timed fade, result.
module acfs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  acfs_pkg::acfs_stat_t stat,
	output acfs_pkg::acfs_cmd_t  cmd
);
	import acfs_pkg::*;

	acfs_state_t         state_q, state_d;
	logic [ITER_W-1:0]   iter_q;
	logic [1:0]          chan_q;

	// State register and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			iter_q  <= '0;
			chan_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_LOAD) begin
				iter_q <= '0;
			end else if (state_q == ST_DIV) begin
				iter_q <= iter_q + 1'b1;
			end
			if (state_q == ST_TGT) begin
				chan_q <= '0;
			end else if (state_q == ST_STORE) begin
				chan_q <= chan_q + 1'b1;
			end
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.chan = chan_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_GREY;
				end
			end
			ST_GREY: begin
				if (stat.no_work) begin
					state_d = ST_DONE;
				end else begin
					cmd.grey_en = 1'b1;
					state_d     = ST_TGT;
				end
			end
			ST_TGT: begin
				cmd.tgt_en = 1'b1;
				state_d    = stat.frames_zero ? ST_DONE : ST_LOAD;
			end
			ST_LOAD: begin
				cmd.div_load = 1'b1;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (iter_q == ITER_W'(DIV_CYC - 1)) begin
					state_d = ST_STORE;
				end
			end
			ST_STORE: begin
				cmd.step_store = 1'b1;
				state_d        = (chan_q == CH_BLUE) ? ST_DONE : ST_LOAD;
			end
			ST_DONE: begin
				// wait for the output register to free up
				if (!stat.out_busy) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### sv/acfs_dp.sv
// Datapath: color registers, target forming, shared serial divider, result register.
module acfs_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  acfs_pkg::acfs_cmd_t              cmd,
	output acfs_pkg::acfs_stat_t             stat,
	// command item
	input  logic [acfs_pkg::MODE_W-1:0]      mode,
	input  logic [acfs_pkg::FRM_W-1:0]       frame_count,
	input  logic signed [acfs_pkg::OFF_W-1:0] red_offset,
	input  logic signed [acfs_pkg::OFF_W-1:0] green_offset,
	input  logic signed [acfs_pkg::OFF_W-1:0] blue_offset,
	// configuration
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [acfs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [acfs_pkg::CH_W-1:0]        cfg_data,
	// result item
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             mode_invalid,
	output logic                             fade_started,
	output logic signed [acfs_pkg::STEP_W-1:0] red_inc,
	output logic signed [acfs_pkg::STEP_W-1:0] green_inc,
	output logic signed [acfs_pkg::STEP_W-1:0] blue_inc,
	output logic                             colour_applied,
	output logic [acfs_pkg::CH_W-1:0]        applied_red,
	output logic [acfs_pkg::CH_W-1:0]        applied_green,
	output logic [acfs_pkg::CH_W-1:0]        applied_blue,
	output logic                             repeat_recorded
);
	import acfs_pkg::*;

	// Captured command
	logic [MODE_W-1:0]       mode_q;
	logic [FRM_W-1:0]        frames_q;
	logic [OFF_W-1:0]        off_q [3];

	// Color state: base from configuration, live whole units
	logic [CH_W-1:0]         base_q [3];
	logic [CH_W-1:0]         live_q [3];

	logic [CH_W-1:0]         grey6_q;
	logic [CH_W-1:0]         tgt_q [3];

	// Divider
	logic [REM_W-1:0]        rem_q;
	logic [DIVD_W-1:0]       dq_q;
	logic                    neg_q;
	logic [STEP_W-1:0]       step_q [3];

	// Result register
	logic                    out_valid_q;
	logic                    mode_invalid_q, fade_started_q, colour_applied_q;
	logic                    repeat_recorded_q;
	logic [STEP_W-1:0]       ostep_q [3];
	logic [CH_W-1:0]         oapp_q [3];

	logic                    work, timed, fz;

	assign fz    = (frames_q == '0);
	assign work  = (mode_q < MODE_CLEAR);
	assign timed = work && !fz;

	assign stat.no_work     = !work;
	assign stat.frames_zero = fz;
	assign stat.out_busy    = out_valid_q && !out_ready;

	assign cfg_ready = 1'b1;

	// Capture command item
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q   <= mode;
			frames_q <= frame_count;
			off_q[0] <= red_offset;
			off_q[1] <= green_offset;
			off_q[2] <= blue_offset;
		end
	end

	// Configuration writes; an index past the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q[0] <= '0;
			base_q[1] <= '0;
			base_q[2] <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_BASE_RED:   base_q[0] <= cfg_data;
				CFG_BASE_GREEN: base_q[1] <= cfg_data;
				CFG_BASE_BLUE:  base_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Grey level of live or base color, divided by six
	logic [CH_W-1:0]        gsrc [3];
	logic [GREY_SUM_W-1:0]  gsum;
	logic [GREY_PROD_W-1:0] gprod;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			gsrc[i] = (mode_q < MODE_BASE_ADD) ? live_q[i] : base_q[i];
		end
		gsum = (GREY_SUM_W'(gsrc[0]) << 1) + GREY_SUM_W'(gsrc[1])
			+ (GREY_SUM_W'(gsrc[1]) << 1) + GREY_SUM_W'(gsrc[2]);
		gprod = GREY_PROD_W'(gsum) * GREY_PROD_W'(GREY6_MUL);
	end

	always_ff @(posedge clk) begin
		if (cmd.grey_en) begin
			grey6_q <= gprod[GREY_SHIFT +: CH_W];
		end
	end

	// Target per channel in whole units, clamped to 0..255
	logic [CH_W-1:0]          pre  [3];
	logic                     use_off [3];
	logic signed [TSUM_W-1:0] tsum [3];
	logic [CH_W-1:0]          tclamp [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			use_off[i] = 1'b1;
			unique case (mode_q)
				MODE_LIVE:        pre[i] = live_q[i];
				MODE_LIVE_HALF:   pre[i] = live_q[i] >> 1;
				MODE_LIVE_GREY6:  pre[i] = grey6_q;
				MODE_LIVE_GREY12: pre[i] = grey6_q >> 1;
				MODE_BASE_HALF:   pre[i] = base_q[i] >> 1;
				MODE_BASE_GREY6:  pre[i] = grey6_q;
				MODE_BASE_GREY12: pre[i] = grey6_q >> 1;
				MODE_BASE_ONLY: begin
					pre[i]     = base_q[i];
					use_off[i] = 1'b0;
				end
				default:          pre[i] = base_q[i];
			endcase
			tsum[i] = $signed({3'b000, pre[i]})
				+ (use_off[i] ? $signed({{(TSUM_W-OFF_W){off_q[i][OFF_W-1]}}, off_q[i]})
				              : $signed(TSUM_W'(0)));
			if (tsum[i][TSUM_W-1]) begin
				tclamp[i] = '0;
			end else if (tsum[i][TSUM_W-2:CH_W] != '0) begin
				tclamp[i] = CH_MAX;
			end else begin
				tclamp[i] = tsum[i][CH_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tgt_en) begin
			for (int i = 0; i < 3; i++) begin
				tgt_q[i] <= tclamp[i];
			end
		end
	end

	// Divider load: |target - live| scaled, sign kept aside
	logic [CH_W:0]   diff;
	logic [CH_W-1:0] mag;

	always_comb begin
		diff = {1'b0, tgt_q[cmd.chan]} - {1'b0, live_q[cmd.chan]};
		mag  = diff[CH_W] ? CH_W'(-diff) : diff[CH_W-1:0];
	end

	// Two restoring division steps per cycle
	logic [REM_W:0]    r1, r2;
	logic [REM_W-1:0]  r1n, r2n;
	logic              ge1, ge2;
	logic [DIVD_W-1:0] d1, d2;

	always_comb begin
		r1  = {rem_q, dq_q[DIVD_W-1]};
		ge1 = (r1 >= {1'b0, frames_q});
		r1n = ge1 ? REM_W'(r1 - {1'b0, frames_q}) : r1[REM_W-1:0];
		d1  = {dq_q[DIVD_W-2:0], ge1};
		r2  = {r1n, d1[DIVD_W-1]};
		ge2 = (r2 >= {1'b0, frames_q});
		r2n = ge2 ? REM_W'(r2 - {1'b0, frames_q}) : r2[REM_W-1:0];
		d2  = {d1[DIVD_W-2:0], ge2};
	end

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			rem_q <= '0;
			dq_q  <= DIVD_W'(mag) << QSHIFT;
			neg_q <= diff[CH_W];
		end else if (cmd.div_step) begin
			rem_q <= r2n;
			dq_q  <= d2;
		end
		if (cmd.step_store) begin
			step_q[cmd.chan] <= neg_q ? STEP_W'(-dq_q) : STEP_W'(dq_q);
		end
	end

	// Live color: loaded by an immediate apply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q[0] <= '0;
			live_q[1] <= '0;
			live_q[2] <= '0;
		end else if (cmd.finish && work && fz) begin
			for (int i = 0; i < 3; i++) begin
				live_q[i] <= tgt_q[i];
			end
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result item; unused fields read zero
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			mode_invalid_q    <= (mode_q > MODE_CLEAR);
			fade_started_q    <= timed;
			repeat_recorded_q <= timed && (mode_q == MODE_BASE_REPEAT);
			colour_applied_q  <= work && fz;
			for (int i = 0; i < 3; i++) begin
				ostep_q[i] <= timed ? step_q[i] : '0;
				oapp_q[i]  <= (work && fz) ? tgt_q[i] : '0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign mode_invalid    = mode_invalid_q;
	assign fade_started    = fade_started_q;
	assign red_inc         = $signed(ostep_q[0]);
	assign green_inc       = $signed(ostep_q[1]);
	assign blue_inc        = $signed(ostep_q[2]);
	assign colour_applied  = colour_applied_q;
	assign applied_red     = oapp_q[0];
	assign applied_green   = oapp_q[1];
	assign applied_blue    = oapp_q[2];
	assign repeat_recorded = repeat_recorded_q;

endmodule

### sv/ambient_color_fade_setup.sv
// After an item is accepted, mode ten and above go from the grey state straight to done; an
// immediate apply also passes the target state; a timed fade adds load, divide and store per channel.
// A new item is taken only once the result is in the output register, and a stalled output holds
// the sequencer in done. Timed fades use the shared serial divider, two quotient bits per cycle.
// Reset clears the live color, base color registers, sequencer and output valid.
module ambient_color_fade_setup (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [acfs_pkg::MODE_W-1:0]        mode,
	input  logic [acfs_pkg::FRM_W-1:0]         frame_count,
	input  logic signed [acfs_pkg::OFF_W-1:0]  red_offset,
	input  logic signed [acfs_pkg::OFF_W-1:0]  green_offset,
	input  logic signed [acfs_pkg::OFF_W-1:0]  blue_offset,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [acfs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [acfs_pkg::CH_W-1:0]          cfg_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               mode_invalid,
	output logic                               fade_started,
	output logic signed [acfs_pkg::STEP_W-1:0] red_inc,
	output logic signed [acfs_pkg::STEP_W-1:0] green_inc,
	output logic signed [acfs_pkg::STEP_W-1:0] blue_inc,
	output logic                               colour_applied,
	output logic [acfs_pkg::CH_W-1:0]          applied_red,
	output logic [acfs_pkg::CH_W-1:0]          applied_green,
	output logic [acfs_pkg::CH_W-1:0]          applied_blue,
	output logic                               repeat_recorded
);
	import acfs_pkg::*;

	acfs_cmd_t  cmd;
	acfs_stat_t stat;

	acfs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	acfs_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.mode            (mode),
		.frame_count     (frame_count),
		.red_offset      (red_offset),
		.green_offset    (green_offset),
		.blue_offset     (blue_offset),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.mode_invalid    (mode_invalid),
		.fade_started    (fade_started),
		.red_inc         (red_inc),
		.green_inc       (green_inc),
		.blue_inc        (blue_inc),
		.colour_applied  (colour_applied),
		.applied_red     (applied_red),
		.applied_green   (applied_green),
		.applied_blue    (applied_blue),
		.repeat_recorded (repeat_recorded)
	);

endmodule

### sim/tb_ambient_color_fade_setup.sv
// Testbench for ambient_color_fade_setup: directed and random fade commands checked by a scoreboard.
`timescale 1ns / 1ps

import acfs_pkg::*;

// One command item as driven on the input channel
typedef struct packed {
	logic [MODE_W-1:0]        mode;
	logic [FRM_W-1:0]         frames;
	logic signed [OFF_W-1:0]  red_offset;
	logic signed [OFF_W-1:0]  green_offset;
	logic signed [OFF_W-1:0]  blue_offset;
} fade_cmd_t;

// One result item as seen on the output channel
typedef struct packed {
	logic                     mode_invalid;
	logic                     fade_started;
	logic signed [STEP_W-1:0] red_inc;
	logic signed [STEP_W-1:0] green_inc;
	logic signed [STEP_W-1:0] blue_inc;
	logic                     colour_applied;
	logic [CH_W-1:0]          applied_red;
	logic [CH_W-1:0]          applied_green;
	logic [CH_W-1:0]          applied_blue;
	logic                     repeat_recorded;
} fade_outcome_t;

// Tracks live and base colors, predicts each outcome and checks results in order
class fade_tracker;
	localparam longint ONE      = longint'(1) << FRAC_BITS;
	localparam longint STEP_HI  = (longint'(1) << (STEP_W - 1)) - 1;
	localparam longint STEP_LO  = -(longint'(1) << (STEP_W - 1));
	localparam int     GREY_DIV = 6;
	localparam int     GREY_DIV_HALF = 12;
	localparam int     STEP_DIV = 1 << STEP_DIV_LOG2;
	localparam int     REPORT_MAX = 10;

	logic [CH_W-1:0]  base_color [3];
	logic [23:0]      live_level [3];
	fade_outcome_t    outcome_q [$];
	int errors, n_checked, n_fades, n_applied, n_invalid, n_cleared, n_recorded;

	function new();
		for (int i = 0; i < 3; i++) begin
			base_color[i] = '0;
			live_level[i] = '0;
		end
		errors = 0;
		n_checked = 0;
		n_fades = 0;
		n_applied = 0;
		n_invalid = 0;
		n_cleared = 0;
		n_recorded = 0;
	endfunction

	function void set_base(logic [CFG_IDX_W-1:0] idx, logic [CH_W-1:0] val);
		case (idx)
			CFG_BASE_RED:   base_color[CH_RED] = val;
			CFG_BASE_GREEN: base_color[CH_GREEN] = val;
			CFG_BASE_BLUE:  base_color[CH_BLUE] = val;
			default: ;
		endcase
	endfunction

	function int pending();
		return outcome_q.size();
	endfunction

	// Truncate to whole units and clamp to the channel range
	function longint whole_units(longint t);
		longint w;
		if (t < 0)
			return 0;
		w = t >>> FRAC_BITS;
		if (w > CH_MAX)
			w = CH_MAX;
		return w << FRAC_BITS;
	endfunction

	// Work out the outcome of one command and advance the live colors
	function fade_outcome_t derive_outcome(fade_cmd_t c);
		fade_outcome_t r;
		longint off [3];
		longint lv [3];
		longint bs [3];
		longint tgt [3];
		longint stp [3];
		longint grey, cur;
		int i;
		r = '0;
		if (c.mode > MODE_CLEAR) begin
			r.mode_invalid = 1'b1;
			return r;
		end
		// clear only drops the replay record, which no output shows
		if (c.mode == MODE_CLEAR)
			return r;
		off[0] = longint'(c.red_offset);
		off[1] = longint'(c.green_offset);
		off[2] = longint'(c.blue_offset);
		for (i = 0; i < 3; i++) begin
			lv[i] = longint'(live_level[i]);
			bs[i] = longint'(base_color[i]);
		end
		for (i = 0; i < 3; i++) begin
			case (c.mode)
				MODE_LIVE:      tgt[i] = lv[i] + off[i] * ONE;
				MODE_LIVE_HALF: tgt[i] = lv[i] / 2 + off[i] * ONE;
				MODE_LIVE_GREY6, MODE_LIVE_GREY12: begin
					grey = (lv[0] * 2 + lv[1] * 3 + lv[2]) /
						((c.mode == MODE_LIVE_GREY6) ? GREY_DIV : GREY_DIV_HALF);
					tgt[i] = grey + off[i] * ONE;
				end
				MODE_BASE_HALF: tgt[i] = (bs[i] * ONE) / 2 + off[i] * ONE;
				MODE_BASE_GREY6, MODE_BASE_GREY12: begin
					grey = (bs[0] * ONE * 2 + bs[1] * ONE * 3 + bs[2] * ONE) /
						((c.mode == MODE_BASE_GREY6) ? GREY_DIV : GREY_DIV_HALF);
					tgt[i] = grey + off[i] * ONE;
				end
				MODE_BASE_ONLY: tgt[i] = bs[i] * ONE;
				default:        tgt[i] = (bs[i] + off[i]) * ONE;
			endcase
			tgt[i] = whole_units(tgt[i]);
		end
		if (c.frames != 0) begin
			// timed fade: step from the whole part of the live level
			for (i = 0; i < 3; i++) begin
				cur = lv[i] & ~(ONE - 1);
				stp[i] = (tgt[i] - cur) / (longint'(c.frames) * STEP_DIV);
				if (stp[i] > STEP_HI)
					stp[i] = STEP_HI;
				if (stp[i] < STEP_LO)
					stp[i] = STEP_LO;
			end
			r.fade_started = 1'b1;
			r.red_inc = STEP_W'(stp[0]);
			r.green_inc = STEP_W'(stp[1]);
			r.blue_inc = STEP_W'(stp[2]);
			r.repeat_recorded = (c.mode == MODE_BASE_REPEAT);
		end else begin
			// immediate apply loads the live colors
			for (i = 0; i < 3; i++)
				live_level[i] = tgt[i][23:0];
			r.colour_applied = 1'b1;
			r.applied_red = CH_W'(tgt[0] >>> FRAC_BITS);
			r.applied_green = CH_W'(tgt[1] >>> FRAC_BITS);
			r.applied_blue = CH_W'(tgt[2] >>> FRAC_BITS);
		end
		return r;
	endfunction

	function void note_input(fade_cmd_t c);
		fade_outcome_t r;
		r = derive_outcome(c);
		outcome_q.push_back(r);
		if (r.mode_invalid)
			n_invalid++;
		else if (c.mode == MODE_CLEAR)
			n_cleared++;
		if (r.fade_started)
			n_fades++;
		if (r.colour_applied)
			n_applied++;
		if (r.repeat_recorded)
			n_recorded++;
	endfunction

	function string fmt(fade_outcome_t r);
		return $sformatf("inv=%0d fade=%0d inc=%0d/%0d/%0d applied=%0d rgb=%0d/%0d/%0d rec=%0d",
			r.mode_invalid, r.fade_started, r.red_inc, r.green_inc, r.blue_inc,
			r.colour_applied, r.applied_red, r.applied_green, r.applied_blue,
			r.repeat_recorded);
	endfunction

	function void check_result(fade_outcome_t got);
		fade_outcome_t exp;
		logic bad;
		n_checked++;
		if (outcome_q.size() == 0) begin
			errors++;
			if (errors <= REPORT_MAX)
				$display("ERROR: result %0d with none expected: %s", n_checked, fmt(got));
			return;
		end
		exp = outcome_q.pop_front();
		bad = (got.mode_invalid !== exp.mode_invalid) ||
			(got.fade_started !== exp.fade_started) ||
			(got.red_inc !== exp.red_inc) ||
			(got.green_inc !== exp.green_inc) ||
			(got.blue_inc !== exp.blue_inc) ||
			(got.colour_applied !== exp.colour_applied) ||
			(got.applied_red !== exp.applied_red) ||
			(got.applied_green !== exp.applied_green) ||
			(got.applied_blue !== exp.applied_blue) ||
			(got.repeat_recorded !== exp.repeat_recorded);
		if (bad) begin
			errors++;
			if (errors <= REPORT_MAX) begin
				$display("ERROR: result %0d mismatch", n_checked);
				$display("  expected %s", fmt(exp));
				$display("  actual   %s", fmt(got));
			end
		end
	endfunction
endclass

module tb_ambient_color_fade_setup;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_LEN       = 300;
	localparam int DRAIN_CYCLES   = 60;
	localparam int PHASE_ITEMS    = 400;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;
	localparam logic [MODE_W-1:0]    MODE_FIRST_BAD = MODE_CLEAR + 4'd1;
	localparam logic [MODE_W-1:0]    MODE_TOP   = 4'hF;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic [MODE_W-1:0]         mode;
	logic [FRM_W-1:0]          frame_count;
	logic signed [OFF_W-1:0]   red_offset;
	logic signed [OFF_W-1:0]   green_offset;
	logic signed [OFF_W-1:0]   blue_offset;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [CH_W-1:0]           cfg_data;
	logic                      out_valid;
	logic                      out_ready;
	logic                      mode_invalid;
	logic                      fade_started;
	logic signed [STEP_W-1:0]  red_inc;
	logic signed [STEP_W-1:0]  green_inc;
	logic signed [STEP_W-1:0]  blue_inc;
	logic                      colour_applied;
	logic [CH_W-1:0]           applied_red;
	logic [CH_W-1:0]           applied_green;
	logic [CH_W-1:0]           applied_blue;
	logic                      repeat_recorded;

	fade_tracker tracker;
	int  send_idle_pct;
	int  recv_idle_pct;
	bit  hold_req;
	int  hold_left;
	int  n_settings;

	ambient_color_fade_setup u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.mode            (mode),
		.frame_count     (frame_count),
		.red_offset      (red_offset),
		.green_offset    (green_offset),
		.blue_offset     (blue_offset),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.mode_invalid    (mode_invalid),
		.fade_started    (fade_started),
		.red_inc         (red_inc),
		.green_inc       (green_inc),
		.blue_inc        (blue_inc),
		.colour_applied  (colour_applied),
		.applied_red     (applied_red),
		.applied_green   (applied_green),
		.applied_blue    (applied_blue),
		.repeat_recorded (repeat_recorded)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic fade_cmd_t cmd_of(logic [MODE_W-1:0] m, int f, int r, int g, int b);
		fade_cmd_t c;
		c.mode = m;
		c.frames = FRM_W'(f);
		c.red_offset = OFF_W'(r);
		c.green_offset = OFF_W'(g);
		c.blue_offset = OFF_W'(b);
		return c;
	endfunction

	function automatic int rand_offset();
		int sel;
		sel = $urandom_range(99);
		if (sel < 40)
			return int'($urandom_range(32)) - 16;
		else if (sel < 80)
			return int'($urandom_range(510)) - 255;
		else if (sel < 90)
			return 255;
		else
			return -255;
	endfunction

	// Mostly valid modes; some clears and invalid codes as noise
	function automatic fade_cmd_t rand_cmd();
		int sel;
		int f;
		logic [MODE_W-1:0] m;
		sel = $urandom_range(99);
		if (sel < 82)
			m = MODE_W'($urandom_range(MODE_BASE_REPEAT));
		else if (sel < 90)
			m = MODE_CLEAR;
		else
			m = MODE_W'($urandom_range(MODE_FIRST_BAD, MODE_TOP));
		sel = $urandom_range(99);
		if (sel < 40)
			f = 0;
		else if (sel < 70)
			f = $urandom_range(1, 8);
		else if (sel < 85)
			f = $urandom_range(9, 1000);
		else if (sel < 95)
			f = $urandom_range(1, 65535);
		else
			f = 65535;
		return cmd_of(m, f, rand_offset(), rand_offset(), rand_offset());
	endfunction

	// Offer one command, idling first at the sender's rate, and wait for accept
	task automatic send_cmd(fade_cmd_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= c.mode;
		frame_count <= c.frames;
		red_offset <= c.red_offset;
		green_offset <= c.green_offset;
		blue_offset <= c.blue_offset;
		do @(posedge clk); while (!in_ready);
		tracker.note_input(c);
	endtask

	// Write the three base registers and the spare index
	task automatic load_base(logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b);
		logic [CFG_IDX_W-1:0] idx [4];
		logic [CH_W-1:0] val [4];
		idx = '{CFG_BASE_RED, CFG_BASE_GREEN, CFG_BASE_BLUE, CFG_SPARE};
		val = '{r, g, b, CH_W'($urandom)};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			do @(posedge clk); while (!cfg_ready);
			tracker.set_base(idx[i], val[i]);
		end
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	task automatic wait_drained(int extra);
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic run_random(int n, int s_pct, int r_pct, bit with_hold);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		for (int k = 0; k < n; k++) begin
			if (with_hold && k == 50)
				hold_req = 1'b1;
			send_cmd(rand_cmd());
		end
		in_valid <= 1'b0;
	endtask

	// Receiver: random stalls, plus one long hold-off on request
	initial begin
		hold_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Result monitor
	initial begin
		fade_outcome_t got;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				got.mode_invalid = mode_invalid;
				got.fade_started = fade_started;
				got.red_inc = red_inc;
				got.green_inc = green_inc;
				got.blue_inc = blue_inc;
				got.colour_applied = colour_applied;
				got.applied_red = applied_red;
				got.applied_green = applied_green;
				got.applied_blue = applied_blue;
				got.repeat_recorded = repeat_recorded;
				tracker.check_result(got);
			end
		end
	end

	// Watchdog on cycles without any accepted item
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("ERROR: no handshake for %0d cycles, %0d results pending",
			WATCHDOG_LIMIT, tracker.pending());
		$display("CHECK FAILED");
		$finish;
	end

	// Main sequence
	initial begin
		tracker = new();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req = 1'b0;
		n_settings = 0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		mode <= MODE_LIVE;
		frame_count <= '0;
		red_offset <= '0;
		green_offset <= '0;
		blue_offset <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_BASE_RED;
		cfg_data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, every mode, most with and without duration, special cases
		load_base(8'd200, 8'd100, 8'd60);
		send_idle_pct = 20;
		recv_idle_pct = 84;
		send_cmd(cmd_of(MODE_LIVE, 0, 255, 255, 255));
		send_cmd(cmd_of(MODE_LIVE, 1, -255, -255, -255));
		send_cmd(cmd_of(MODE_LIVE, 0, -255, -255, -255));
		send_cmd(cmd_of(MODE_LIVE, 1, 255, 255, 255));
		send_cmd(cmd_of(MODE_LIVE, 65535, 100, -1, 37));
		send_cmd(cmd_of(MODE_LIVE, 0, 180, 90, 30));
		send_cmd(cmd_of(MODE_LIVE_HALF, 0, 3, -2, 1));
		send_cmd(cmd_of(MODE_LIVE_HALF, 2, 40, -40, 0));
		send_cmd(cmd_of(MODE_LIVE_GREY6, 0, 0, 0, 0));
		send_cmd(cmd_of(MODE_LIVE_GREY12, 5, 10, -10, 0));
		send_cmd(cmd_of(MODE_LIVE_GREY12, 0, 7, 8, -9));
		send_cmd(cmd_of(MODE_LIVE_GREY6, 3, 200, -200, 50));
		send_cmd(cmd_of(MODE_BASE_ADD, 0, 100, -100, -255));
		send_cmd(cmd_of(MODE_BASE_ADD, 7, -1, 1, 255));
		send_cmd(cmd_of(MODE_BASE_HALF, 0, 1, 1, 1));
		send_cmd(cmd_of(MODE_BASE_HALF, 3, -100, 0, 255));
		send_cmd(cmd_of(MODE_BASE_GREY6, 0, 20, -20, 0));
		send_cmd(cmd_of(MODE_BASE_GREY12, 2, 0, 255, -255));
		send_cmd(cmd_of(MODE_BASE_ONLY, 0, 255, -255, 17));
		send_cmd(cmd_of(MODE_BASE_ONLY, 9, -3, 3, 0));
		// mode nine without duration records nothing
		send_cmd(cmd_of(MODE_BASE_REPEAT, 0, 5, 5, 5));
		send_cmd(cmd_of(MODE_BASE_REPEAT, 4, -5, 6, 7));
		send_cmd(cmd_of(MODE_CLEAR, 12, 255, -255, 3));
		send_cmd(cmd_of(MODE_FIRST_BAD, 0, 1, 2, 3));
		send_cmd(cmd_of(MODE_TOP, 77, -255, 255, -1));
		in_valid <= 1'b0;
		wait_drained(8);

		// Random phases across base settings and idle profiles
		load_base(8'd0, 8'd0, 8'd0);
		run_random(PHASE_ITEMS, 20, 84, 1'b0);
		wait_drained(8);
		load_base(8'd255, 8'd255, 8'd255);
		run_random(PHASE_ITEMS, 84, 20, 1'b0);
		wait_drained(8);
		load_base(CH_W'($urandom_range(255)), CH_W'($urandom_range(255)),
			CH_W'($urandom_range(255)));
		run_random(PHASE_ITEMS, 0, 0, 1'b1);
		wait_drained(8);
		load_base(CH_W'($urandom_range(255)), CH_W'($urandom_range(255)),
			CH_W'($urandom_range(255)));
		run_random(PHASE_ITEMS, 0, 0, 1'b0);
		wait_drained(DRAIN_CYCLES);

		$display("Checked %0d results over %0d base settings: %0d fades, %0d immediate applies",
			tracker.n_checked, n_settings, tracker.n_fades, tracker.n_applied);
		$display("  %0d invalid modes, %0d record clears, %0d recorded repeats, %0d errors",
			tracker.n_invalid, tracker.n_cleared, tracker.n_recorded, tracker.errors);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

### filelist.f
sv/acfs_pkg.sv
sv/acfs_ctrl.sv
sv/acfs_dp.sv
sv/ambient_color_fade_setup.sv
sim/tb_ambient_color_fade_setup.sv
